>>> rtl/psd_pkg.sv
// Shared widths and the front-end word type for the point-to-segment distance unit.
package psd_pkg;

  localparam int COORD_W = 16;
  localparam int FRAC_W  = 8;
  localparam int OUT_W   = 25;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int HALF_W  = PROD_W / 2;
  localparam int SQ_W    = PROD_W;
  localparam int NUM_W   = 2 * SQ_W;
  localparam int SHIFT_W = 2 * FRAC_W + 2;
  localparam int N_W     = NUM_W + SHIFT_W;
  localparam int Q_W     = 2 * (SQ_W + FRAC_W + 1) - SQ_W;
  localparam int ROOT_W  = Q_W / 2;
  localparam int DREM_W  = N_W - Q_W;
  localparam int SREM_W  = ROOT_W + 1;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [SQ_W-1:0]  den;
  } psd_frac_t;

endpackage

>>> rtl/psd_front.sv
// Geometry front end: differences, products, case select and squared numerator.
module psd_front
  import psd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic signed [COORD_W-1:0] sx,
  input  logic signed [COORD_W-1:0] sy,
  input  logic signed [COORD_W-1:0] ex,
  input  logic signed [COORD_W-1:0] ey,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  output logic                      out_vld,
  output logic                      out_ep,
  output psd_frac_t                 out_frac
);

  logic [4:0] vld_r;

  logic signed [DIFF_W-1:0] dx_r, dy_r, ux_r, uy_r, vx_r, vy_r;
  logic signed [PROD_W-1:0] udx_r, udy_r, vdx_r, vdy_r, dxuy_r, dyux_r;
  logic signed [PROD_W-1:0] uxx_r, uyy_r, vxx_r, vyy_r, dxx_r, dyy_r;

  logic signed [PROD_W:0] dot1, dot2n, crs;
  logic [SQ_W-1:0] cr_abs;
  logic            ep3_r;
  logic [SQ_W-1:0] cr3_r, a2_r, b2_r, den3_r;

  logic            ep4_r;
  logic [SQ_W-1:0] mn4_r, den4_r;
  logic [PROD_W-1:0] hh_r, hl_r, ll_r;

  logic            ep5_r;
  psd_frac_t       frac5_r;
  logic [NUM_W-1:0] sq_num;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  assign dot1   = {udx_r[PROD_W-1], udx_r} + {udy_r[PROD_W-1], udy_r};
  assign dot2n  = {vdx_r[PROD_W-1], vdx_r} + {vdy_r[PROD_W-1], vdy_r};
  assign crs    = {dxuy_r[PROD_W-1], dxuy_r} - {dyux_r[PROD_W-1], dyux_r};
  assign cr_abs = crs[PROD_W] ? SQ_W'(-crs) : SQ_W'(crs);

  // cr^2 = hh<<2H + 2*hl<<H + ll
  assign sq_num = {hh_r, {PROD_W{1'b0}}}
                + {{(NUM_W-PROD_W-HALF_W-1){1'b0}}, hl_r, {(HALF_W+1){1'b0}}}
                + {{(NUM_W-PROD_W){1'b0}}, ll_r};

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= DIFF_W'(ex) - DIFF_W'(sx);
      dy_r <= DIFF_W'(ey) - DIFF_W'(sy);
      ux_r <= DIFF_W'(px) - DIFF_W'(sx);
      uy_r <= DIFF_W'(py) - DIFF_W'(sy);
      vx_r <= DIFF_W'(px) - DIFF_W'(ex);
      vy_r <= DIFF_W'(py) - DIFF_W'(ey);

      udx_r  <= ux_r * dx_r;
      udy_r  <= uy_r * dy_r;
      vdx_r  <= vx_r * dx_r;
      vdy_r  <= vy_r * dy_r;
      dxuy_r <= dx_r * uy_r;
      dyux_r <= dy_r * ux_r;
      uxx_r  <= ux_r * ux_r;
      uyy_r  <= uy_r * uy_r;
      vxx_r  <= vx_r * vx_r;
      vyy_r  <= vy_r * vy_r;
      dxx_r  <= dx_r * dx_r;
      dyy_r  <= dy_r * dy_r;

      // outside the segment when either dot product is <= 0
      ep3_r  <= (dot1 <= 0) || (dot2n >= 0);
      cr3_r  <= cr_abs;
      a2_r   <= SQ_W'(uxx_r) + SQ_W'(uyy_r);
      b2_r   <= SQ_W'(vxx_r) + SQ_W'(vyy_r);
      den3_r <= SQ_W'(dxx_r) + SQ_W'(dyy_r);

      ep4_r  <= ep3_r;
      mn4_r  <= (a2_r <= b2_r) ? a2_r : b2_r;
      den4_r <= den3_r;
      hh_r   <= cr3_r[SQ_W-1:HALF_W] * cr3_r[SQ_W-1:HALF_W];
      hl_r   <= cr3_r[SQ_W-1:HALF_W] * cr3_r[HALF_W-1:0];
      ll_r   <= cr3_r[HALF_W-1:0] * cr3_r[HALF_W-1:0];

      ep5_r       <= ep4_r;
      frac5_r.num <= ep4_r ? {{(NUM_W-SQ_W){1'b0}}, mn4_r} : sq_num;
      frac5_r.den <= ep4_r ? SQ_W'(1) : den4_r;
    end
  end

  assign out_vld  = vld_r[4];
  assign out_ep   = ep5_r;
  assign out_frac = frac5_r;

endmodule

>>> rtl/point_segment_distance_unit.sv
// Point-to-segment distance unit: front end, pipelined divider and square root.
// Pipeline from accepted input word to output word: 5 front-end stages,
// 52 divider stages, 26 square-root stages, 1 output stage.
// Throughput: one word per cycle; the whole pipeline holds while the output stalls.
// Reset (synchronous, rst_n low) clears all valid bits; data registers are not reset.
module point_segment_distance_unit
  import psd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic signed [COORD_W-1:0] in_end_x,
  input  logic signed [COORD_W-1:0] in_end_y,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [OUT_W-1:0]          out_dist_res
);

  logic      en;
  logic      f_vld, f_ep;
  psd_frac_t f_frac;
  logic [N_W-1:0] n_full;

  logic [Q_W:0]       dv_r;
  logic [DREM_W-1:0]  drem_r [Q_W+1];
  logic [Q_W-1:0]     dq_r   [Q_W+1];
  logic [SQ_W-1:0]    dden_r [Q_W+1];

  logic [ROOT_W:0]    sv_r;
  logic [Q_W-1:0]     sx_r   [ROOT_W+1];
  logic [SREM_W-1:0]  srem_r [ROOT_W+1];
  logic [ROOT_W-1:0]  sroot_r[ROOT_W+1];

  logic              out_valid_r;
  logic [OUT_W-1:0]  out_dist_res_r;
  logic [ROOT_W:0]   rnd;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  psd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .sx       (in_start_x),
    .sy       (in_start_y),
    .ex       (in_end_x),
    .ey       (in_end_y),
    .px       (in_point_x),
    .py       (in_point_y),
    .out_vld  (f_vld),
    .out_ep   (f_ep),
    .out_frac (f_frac)
  );

  assign n_full = {f_frac.num, {SHIFT_W{1'b0}}};

  // stage 0 of the divider: top bits already below den
  always_comb begin
    dv_r[0]   = f_vld;
    drem_r[0] = n_full[N_W-1:Q_W];
    dq_r[0]   = n_full[Q_W-1:0];
    dden_r[0] = f_frac.den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[Q_W:1] <= '0;
      sv_r[ROOT_W:1] <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      dv_r[Q_W:1]    <= dv_r[Q_W-1:0];
      sv_r[ROOT_W:1] <= sv_r[ROOT_W-1:0];
      out_valid_r    <= sv_r[ROOT_W];
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    logic [DREM_W:0] t;
    logic            ge;
    assign t  = {drem_r[k], dq_r[k][Q_W-1]};
    assign ge = t >= {1'b0, dden_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[k+1] <= ge ? DREM_W'(t - {1'b0, dden_r[k]}) : DREM_W'(t);
        dq_r[k+1]   <= {dq_r[k][Q_W-2:0], ge};
        dden_r[k+1] <= dden_r[k];
      end
    end
  end

  always_comb begin
    sv_r[0]    = dv_r[Q_W];
    sx_r[0]    = dq_r[Q_W];
    srem_r[0]  = '0;
    sroot_r[0] = '0;
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    logic [SREM_W+1:0] t;
    logic [SREM_W+1:0] trial;
    logic              ge;
    assign t     = {srem_r[j], sx_r[j][Q_W-1:Q_W-2]};
    assign trial = {1'b0, sroot_r[j], 2'b01};
    assign ge    = t >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[j+1]  <= ge ? SREM_W'(t - trial) : SREM_W'(t);
        sroot_r[j+1] <= {sroot_r[j][ROOT_W-2:0], ge};
        sx_r[j+1]    <= {sx_r[j][Q_W-3:0], 2'b00};
      end
    end
  end

  // r = largest with (2r-1) <= isqrt(Q)
  assign rnd = {1'b0, sroot_r[ROOT_W]} + (ROOT_W+1)'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      out_dist_res_r <= OUT_W'(rnd[ROOT_W:1]);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dist_res = out_dist_res_r;

  a_div_rem : assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[Q_W] |-> (drem_r[Q_W] < dden_r[Q_W]))
    else $error("divider remainder not below divisor");

  a_ep_den : assert property (@(posedge clk) disable iff (!rst_n)
    (f_vld && f_ep) |-> (f_frac.den == SQ_W'(1)))
    else $error("endpoint case with divisor other than one");

  a_root_rem : assert property (@(posedge clk) disable iff (!rst_n)
    sv_r[ROOT_W] |-> ({1'b0, srem_r[ROOT_W]} <= {sroot_r[ROOT_W], 1'b0}))
    else $error("square root remainder out of range");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(dv_r) && $stable(sv_r)))
    else $error("pipeline moved while output stalled");

endmodule

>>> tb/sv/psd_checker.sv
// Checker for the point-to-segment distance unit: predicts each distance and compares.
module psd_checker
  import psd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic signed [COORD_W-1:0] in_end_x,
  input  logic signed [COORD_W-1:0] in_end_y,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [OUT_W-1:0]          out_dist_res,
  output int                        fail_count,
  output int                        dist_pending,
  output int                        perp_count,
  output int                        dist_checked
);

  logic [OUT_W-1:0] dist_queue[$];
  int               perp_seen;

  // Exact distance * 2^FRAC_W, rounded to nearest with ties up.
  function automatic logic [OUT_W-1:0] seg_distance(
    input logic signed [COORD_W-1:0] sx, sy, ex, ey, px, py,
    output bit perp);
    longint     dx, dy, ux, uy, vx, vy, dot1, dot2, a2, b2, cr;
    bit [127:0] num, den, lhs, t, crw;
    logic [OUT_W-1:0] r;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    ux = longint'(px) - longint'(sx);
    uy = longint'(py) - longint'(sy);
    vx = longint'(px) - longint'(ex);
    vy = longint'(py) - longint'(ey);
    dot1 = ux * dx + uy * dy;
    dot2 = -(vx * dx + vy * dy);
    perp = !(dot1 <= 0 || dot2 <= 0);
    if (!perp) begin
      // projection falls outside: nearer endpoint
      a2 = ux * ux + uy * uy;
      b2 = vx * vx + vy * vy;
      num = 128'((a2 <= b2) ? a2 : b2);
      den = 128'd1;
    end else begin
      cr = dx * uy - dy * ux;
      if (cr < 0) cr = -cr;
      crw = 128'(cr);
      num = crw * crw;
      den = 128'(dx * dx + dy * dy);
    end
    num = num << (2 * FRAC_W + 2);
    r = '0;
    for (int b = OUT_W - 1; b >= 0; b--) begin
      t = 2 * ({103'd0, r} | (128'd1 << b)) - 1;
      lhs = t * t * den;
      if (lhs <= num) r[b] = 1'b1;
    end
    return r;
  endfunction

  assign dist_pending = dist_queue.size();
  assign perp_count   = perp_seen;

  always @(posedge clk) begin
    bit               perp;
    logic [OUT_W-1:0] want;
    if (!rst_n) begin
      fail_count   <= 0;
      perp_seen    <= 0;
      dist_checked <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        dist_queue.push_back(seg_distance(in_start_x, in_start_y, in_end_x, in_end_y,
                                          in_point_x, in_point_y, perp));
        if (perp) perp_seen <= perp_seen + 1;
      end
      if (out_valid && !out_stall) begin
        if (dist_queue.size() == 0) begin
          $error("unexpected output word: dist_res actual %0d", out_dist_res);
          fail_count <= fail_count + 1;
        end else begin
          want = dist_queue.pop_front();
          dist_checked <= dist_checked + 1;
          if (out_dist_res !== want) begin
            $error("dist_res mismatch: expected %0d actual %0d", want, out_dist_res);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the point-to-segment distance testbench: clock, reset, stimulus and verdict.
module testbench;
  import psd_pkg::*;

  localparam int RANDOM_WORDS = 1500;
  localparam int QUIET_WORDS  = 200;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_start_x = '0, in_start_y = '0, in_end_x = '0;
  logic signed [COORD_W-1:0] in_end_y = '0, in_point_x = '0, in_point_y = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [OUT_W-1:0]          out_dist_res;
  int                        fail_count, dist_pending, perp_count, dist_checked;
  int                        words_sent;
  bit                        quiet;

  always #1 clk = ~clk;

  point_segment_distance_unit u_top (.*);

  psd_checker u_checker (.*);

  // receiver stalls in random bursts, except in the quiet phase
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!quiet && rst_n && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic signed [COORD_W-1:0] sx, sy, ex, ey, px, py);
    in_start_x <= sx; in_start_y <= sy;
    in_end_x   <= ex; in_end_y   <= ey;
    in_point_x <= px; in_point_y <= py;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic logic signed [COORD_W-1:0] near(input int c, input int spread);
    int v;
    v = c + $urandom_range(0, 2 * spread) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return COORD_W'(v);
  endfunction

  initial begin
    logic signed [COORD_W-1:0] sx, sy, ex, ey, px, py;
    int lim, t;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_word(0, 0, 0, 0, 0, 0);                        // degenerate segment, point on it
    send_word(5, 5, 5, 5, -3, 9);                       // zero-length segment
    send_word(-32768, -32768, 32767, 32767, 32767, -32768); // widest diagonal, perpendicular
    send_word(-32768, -32768, 32767, 32767, -32768, 32767);
    send_word(32767, 32767, 32767, 32767, -32768, -32768); // largest endpoint distance
    send_word(-32768, 0, 32767, 0, 0, 32767);           // perpendicular, full height
    send_word(-32768, 0, 32767, 0, 0, -32768);
    send_word(0, 0, 10, 0, 0, 7);                       // projects onto the start point
    send_word(0, 0, 10, 0, 10, 7);                      // projects onto the end point
    send_word(0, 0, 10, 0, -4, 3);                      // beyond the start
    send_word(0, 0, 10, 0, 15, -3);                     // beyond the end
    send_word(0, 0, 10, 0, 5, 0);                       // on the segment
    send_word(0, 0, 10, 0, 20, 0);                      // collinear, outside
    send_word(0, 0, 1, 1, 1, 0);                        // half-unit rounding cases
    send_word(0, 0, 3, 0, 1, 1);
    send_word(0, 0, 2, 1, 1, 3);
    send_word(-1, -1, -1, -1, 0, 0);
    send_word(32767, -32768, -32768, 32767, 0, 0);
    send_word(-32768, -32768, -32768, 32767, 32767, 0);
    send_word(32767, 32767, -32768, 32767, 0, -32768);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      quiet = (i >= RANDOM_WORDS - QUIET_WORDS);
      lim = ($urandom_range(0, 3) == 0) ? 32768 : 64;
      sx = COORD_W'($urandom); sy = COORD_W'($urandom);
      ex = COORD_W'($urandom); ey = COORD_W'($urandom);
      px = COORD_W'($urandom); py = COORD_W'($urandom);
      case ($urandom_range(0, 3))
        0: ; // full range anywhere
        1: begin // point near a position along the segment
          t = $urandom_range(0, 16);
          px = near(sx + (int'(ex) - int'(sx)) * t / 16, lim);
          py = near(sy + (int'(ey) - int'(sy)) * t / 16, lim);
        end
        2: begin // short segment, nearby point
          ex = near(sx, lim); ey = near(sy, lim);
          px = near(sx, 2 * lim); py = near(sy, 2 * lim);
        end
        default: begin // rails and near-degenerate segments
          if ($urandom_range(0, 1)) ex = sx; else ey = sy;
          if ($urandom_range(0, 3) == 0) begin ex = sx; ey = sy; end
          px = near(sx, lim); py = near(sy, lim);
        end
      endcase
      send_word(sx, sy, ex, ey, px, py);
    end
    in_valid <= 1'b0;

    lim = 0;
    while (dist_pending != 0 && lim < 10000) begin
      @(posedge clk);
      lim++;
    end
    repeat (120) @(posedge clk);
    $display("Sent %0d query words, checked %0d distances, %0d in the perpendicular case.",
             words_sent, dist_checked, perp_count);
    if (fail_count == 0 && dist_pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/psd_pkg.sv
rtl/psd_front.sv
rtl/point_segment_distance_unit.sv
tb/sv/psd_checker.sv
tb/sv/testbench.sv
